// ===== rtl/mesh_face_area_defines.svh =====
// Assertion macros used by mesh_face_area.sv to check its own logic.
`ifndef MESH_FACE_AREA_DEFINES_SVH
`define MESH_FACE_AREA_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MFA_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mesh_face_area: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define MFA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mesh_face_area: assertion failed");

`endif

// ===== rtl/mfa_pkg.sv =====
package mfa_pkg;

    localparam int OUT_BITS = 35;

    typedef enum logic [1:0] {
        KIND_POINT    = 2'd0,
        KIND_INTERVAL = 2'd1,
        KIND_TRIANGLE = 2'd2,
        KIND_PGRAM    = 2'd3
    } kind_t;

    // Control handed from one square root cell to the next.
    typedef struct packed {
        logic valid;
    } mfa_ctl_t;

endpackage

// ===== rtl/mfa_if.sv =====
interface mfa_face_if #(parameter int COORD_BITS = 16);
    logic                         valid;
    logic                         ready;
    logic [1:0]                   action;
    logic signed [COORD_BITS-1:0] v0_x;
    logic signed [COORD_BITS-1:0] v0_y;
    logic signed [COORD_BITS-1:0] v0_z;
    logic signed [COORD_BITS-1:0] v1_x;
    logic signed [COORD_BITS-1:0] v1_y;
    logic signed [COORD_BITS-1:0] v1_z;
    logic signed [COORD_BITS-1:0] v2_x;
    logic signed [COORD_BITS-1:0] v2_y;
    logic signed [COORD_BITS-1:0] v2_z;

    modport source (output valid, action, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z,
                    v2_x, v2_y, v2_z, input ready);
    modport sink   (input valid, action, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z,
                    v2_x, v2_y, v2_z, output ready);
endinterface

interface mfa_area_if;
    logic        valid;
    logic        ready;
    logic [34:0] area_halves;

    modport source (output valid, area_halves, input ready);
    modport sink   (input valid, area_halves, output ready);
endinterface

// ===== rtl/mfa_front.sv =====
module mfa_front
    import mfa_pkg::*;
#(
    parameter int COORD_BITS = 16,
    parameter int RAD_BITS   = 2 * (2 * (COORD_BITS + 1) + 1) + 4
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic [1:0]                   action,
    input  logic signed [COORD_BITS-1:0] v0_x,
    input  logic signed [COORD_BITS-1:0] v0_y,
    input  logic signed [COORD_BITS-1:0] v0_z,
    input  logic signed [COORD_BITS-1:0] v1_x,
    input  logic signed [COORD_BITS-1:0] v1_y,
    input  logic signed [COORD_BITS-1:0] v1_z,
    input  logic signed [COORD_BITS-1:0] v2_x,
    input  logic signed [COORD_BITS-1:0] v2_y,
    input  logic signed [COORD_BITS-1:0] v2_z,
    output mfa_ctl_t                     ctl,
    output logic [RAD_BITS-1:0]          rad
);
    localparam int D = COORD_BITS + 1;
    localparam int Q = 2 * D;
    localparam int P = Q + 1;

    // Stage 1: edge vectors.
    logic [3:0] vld_reg;
    kind_t k1_reg, k2_reg, k3_reg, k4_reg;
    logic signed [D-1:0] ax_reg, ay_reg, az_reg, bx_reg, by_reg, bz_reg;
    // Stage 2: products.
    logic signed [Q-1:0] p_yz_reg, p_zy_reg, p_zx_reg, p_xz_reg, p_xy_reg, p_yx_reg;
    logic signed [Q-1:0] sx_reg, sy_reg, sz_reg;
    // Stage 3: cross product magnitudes and edge length squared.
    logic [P-1:0] m1_reg, m2_reg, m3_reg, len_reg;
    // Stage 4: squares.
    logic [2*P-1:0] q1_reg, q2_reg, q3_reg;
    logic [P-1:0]   len4_reg;
    // Stage 5: radicand.
    logic [RAD_BITS-1:0] rad_reg;

    logic signed [P-1:0] c1, c2, c3;
    logic [RAD_BITS-1:0] sum_c, rad_next;

    always_comb
    begin
        c1 = P'(p_yz_reg) - P'(p_zy_reg);
        c2 = P'(p_zx_reg) - P'(p_xz_reg);
        c3 = P'(p_xy_reg) - P'(p_yx_reg);
        sum_c = RAD_BITS'(q1_reg) + RAD_BITS'(q2_reg) + RAD_BITS'(q3_reg);
        case (k4_reg)
            KIND_POINT:    rad_next = RAD_BITS'(4);
            KIND_INTERVAL: rad_next = RAD_BITS'(len4_reg) << 2;
            KIND_TRIANGLE: rad_next = sum_c;
            KIND_PGRAM:    rad_next = sum_c << 2;
            default:       rad_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            k1_reg <= kind_t'(action);
            ax_reg <= D'(v1_x) - D'(v0_x);
            ay_reg <= D'(v1_y) - D'(v0_y);
            az_reg <= D'(v1_z) - D'(v0_z);
            bx_reg <= D'(v2_x) - D'(v0_x);
            by_reg <= D'(v2_y) - D'(v0_y);
            bz_reg <= D'(v2_z) - D'(v0_z);

            k2_reg   <= k1_reg;
            p_yz_reg <= ay_reg * bz_reg;
            p_zy_reg <= az_reg * by_reg;
            p_zx_reg <= az_reg * bx_reg;
            p_xz_reg <= ax_reg * bz_reg;
            p_xy_reg <= ax_reg * by_reg;
            p_yx_reg <= ay_reg * bx_reg;
            sx_reg   <= ax_reg * ax_reg;
            sy_reg   <= ay_reg * ay_reg;
            sz_reg   <= az_reg * az_reg;

            k3_reg  <= k2_reg;
            m1_reg  <= c1[P-1] ? P'(-c1) : P'(c1);
            m2_reg  <= c2[P-1] ? P'(-c2) : P'(c2);
            m3_reg  <= c3[P-1] ? P'(-c3) : P'(c3);
            len_reg <= P'(unsigned'(sx_reg)) + P'(unsigned'(sy_reg))
                       + P'(unsigned'(sz_reg));

            k4_reg   <= k3_reg;
            q1_reg   <= m1_reg * m1_reg;
            q2_reg   <= m2_reg * m2_reg;
            q3_reg   <= m3_reg * m3_reg;
            len4_reg <= len_reg;

            rad_reg <= rad_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl.valid <= 1'b0;
        else if (en)
            ctl.valid <= vld_reg[3];
    end

    assign rad = rad_reg;
endmodule

// ===== rtl/mfa_sqrt_cell.sv =====
module mfa_sqrt_cell
    import mfa_pkg::*;
#(
    parameter int RAD_BITS = 74
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  mfa_ctl_t                ctl_in,
    input  logic [RAD_BITS-1:0]     rad_in,
    input  logic [RAD_BITS/2:0]     rem_in,
    input  logic [RAD_BITS/2-1:0]   root_in,
    output mfa_ctl_t                ctl_out,
    output logic [RAD_BITS-1:0]     rad_out,
    output logic [RAD_BITS/2:0]     rem_out,
    output logic [RAD_BITS/2-1:0]   root_out
);
    localparam int R = RAD_BITS / 2;

    logic [R+2:0]          part, trial;
    logic                  fits;
    logic [RAD_BITS-1:0]   rad_reg;
    logic [R:0]            rem_reg, rem_next;
    logic [R-1:0]          root_reg, root_next;

    // One result bit per cell: bring down two radicand bits, try 4*root+1.
    always_comb
    begin
        part      = {rem_in, rad_in[RAD_BITS-1 -: 2]};
        trial     = {1'b0, root_in, 2'b01};
        fits      = part >= trial;
        rem_next  = fits ? (R+1)'(part - trial) : (R+1)'(part);
        root_next = {root_in[R-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl_out.valid <= 1'b0;
        else if (en)
            ctl_out.valid <= ctl_in.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad_reg  <= rad_in << 2;
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign rad_out  = rad_reg;
    assign rem_out  = rem_reg;
    assign root_out = root_reg;
endmodule

// ===== rtl/mesh_face_area.sv =====
// Face measure pipeline: one face request is taken every cycle unless a stalled result
// holds the pipeline. Each request passes through five register stages of edge vectors,
// products, cross product, squaring and radicand, then one square root cell per result
// bit (COORD_BITS*2 + 5 of them). The whole pipeline advances together, so a stalled
// result holds every stage until it is taken.
// Results above 35 bits saturate to all ones.
`include "mesh_face_area_defines.svh"

module mesh_face_area
    import mfa_pkg::*;
#(
    parameter int COORD_BITS = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    mfa_face_if.sink   face,
    mfa_area_if.source area
);
    localparam int P = 2 * (COORD_BITS + 1) + 1;
    localparam int N = 2 * P + 4;
    localparam int R = N / 2;

    logic en;
    mfa_ctl_t        ctl  [R+1];
    logic [N-1:0]    rad  [R+1];
    logic [R:0]      rem  [R+1];
    logic [R-1:0]    root [R+1];

    assign en         = !ctl[R].valid || area.ready;
    assign face.ready = en;

    mfa_front #(.COORD_BITS(COORD_BITS), .RAD_BITS(N)) u_front (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(face.valid),
        .action(face.action),
        .v0_x(face.v0_x), .v0_y(face.v0_y), .v0_z(face.v0_z),
        .v1_x(face.v1_x), .v1_y(face.v1_y), .v1_z(face.v1_z),
        .v2_x(face.v2_x), .v2_y(face.v2_y), .v2_z(face.v2_z),
        .ctl(ctl[0]), .rad(rad[0])
    );

    assign rem[0]  = '0;
    assign root[0] = '0;

    for (genvar i = 0; i < R; i++)
    begin : g_cell
        mfa_sqrt_cell #(.RAD_BITS(N)) u_cell (
            .clk(clk), .rst_n(rst_n), .en(en),
            .ctl_in(ctl[i]), .rad_in(rad[i]), .rem_in(rem[i]), .root_in(root[i]),
            .ctl_out(ctl[i+1]), .rad_out(rad[i+1]), .rem_out(rem[i+1]),
            .root_out(root[i+1])
        );
    end

    assign area.valid       = ctl[R].valid;
    assign area.area_halves = (root[R] > R'({OUT_BITS{1'b1}})) ? {OUT_BITS{1'b1}}
                              : OUT_BITS'(root[R]);

    `MFA_ASSERT_NOW(a_ready_rule, 1'b1, face.ready == (!area.valid || area.ready))
    `MFA_ASSERT_NEXT(a_stall_holds, area.valid && !area.ready, $stable(root[R]))
    `MFA_ASSERT_NOW(a_out_known, area.valid, !$isunknown(area.area_halves))
endmodule

// ===== dv/mesh_face_area_tb.sv =====
`timescale 1ns / 1ps

module mesh_face_area_tb;
    import mfa_pkg::*;

    localparam int CB         = 16;
    localparam int RANDOM_N   = 1030;
    localparam int QUIET_TAIL = 150;
    localparam int LONG_HOLD  = 300;
    localparam int IDLE_LIMIT = 2000;
    localparam int DRAIN_WAIT = 100;
    localparam logic [OUT_BITS-1:0] AREA_MAX = '1;

    typedef struct {
        kind_t                kind;
        logic signed [CB-1:0] c [9];
    } face_t;

    typedef struct {
        face_t               f;
        bit                  has_exp;
        logic [OUT_BITS-1:0] exp_val;
    } face_row_t;

    logic clk;
    logic rst_n;

    mfa_face_if #(.COORD_BITS(CB)) face_ch ();
    mfa_area_if                    area_ch ();

    mesh_face_area #(.COORD_BITS(CB)) dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .face  (face_ch),
        .area  (area_ch)
    );

    logic [OUT_BITS-1:0] area_q [$];
    face_row_t           directed_rows [$];
    int  errors;
    int  faces_sent;
    int  areas_seen;
    int  kind_count [4];
    int  idle_cycles;
    bit  quiet;
    bit  hold_req;
    bit  stim_done;

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Twice the face measure, rounded down, from exact integer arithmetic.
    function automatic logic [OUT_BITS-1:0] face_area_halves(face_t f);
        longint      ax, ay, az, bx, by, bz;
        longint      v [3];
        logic [127:0] sum_sq;
        logic [127:0] m;
        logic [63:0]  root;
        logic [63:0]  cand;
        if (f.kind == KIND_POINT)
            return OUT_BITS'(2);
        ax = longint'(f.c[3]) - longint'(f.c[0]);
        ay = longint'(f.c[4]) - longint'(f.c[1]);
        az = longint'(f.c[5]) - longint'(f.c[2]);
        bx = longint'(f.c[6]) - longint'(f.c[0]);
        by = longint'(f.c[7]) - longint'(f.c[1]);
        bz = longint'(f.c[8]) - longint'(f.c[2]);
        if (f.kind == KIND_INTERVAL)
        begin
            v[0] = ax;
            v[1] = ay;
            v[2] = az;
        end
        else
        begin
            v[0] = ay * bz - az * by;
            v[1] = az * bx - ax * bz;
            v[2] = ax * by - ay * bx;
        end
        sum_sq = '0;
        for (int i = 0; i < 3; i++)
        begin
            m = (v[i] < 0) ? 128'(-v[i]) : 128'(v[i]);
            sum_sq += m * m;
        end
        if (f.kind != KIND_TRIANGLE)
            sum_sq = sum_sq << 2;
        root = '0;
        for (int b = 63; b >= 0; b--)
        begin
            cand = root | (64'd1 << b);
            if (128'(cand) * 128'(cand) <= sum_sq)
                root = cand;
        end
        if (root > 64'(AREA_MAX))
            return AREA_MAX;
        return root[OUT_BITS-1:0];
    endfunction

    function automatic face_t make_face(kind_t k, int x0, int y0, int z0, int x1, int y1,
                                        int z1, int x2, int y2, int z2);
        face_t f;
        f.kind = k;
        f.c[0] = x0[CB-1:0]; f.c[1] = y0[CB-1:0]; f.c[2] = z0[CB-1:0];
        f.c[3] = x1[CB-1:0]; f.c[4] = y1[CB-1:0]; f.c[5] = z1[CB-1:0];
        f.c[6] = x2[CB-1:0]; f.c[7] = y2[CB-1:0]; f.c[8] = z2[CB-1:0];
        return f;
    endfunction

    task automatic add_row(face_t f, bit has_exp, logic [OUT_BITS-1:0] exp_val);
        face_row_t r;
        r.f       = f;
        r.has_exp = has_exp;
        r.exp_val = exp_val;
        directed_rows = {directed_rows, r};
    endtask

    function automatic int pick_coord(int mode);
        int corners [4];
        corners = '{-32768, 32767, 0, -1};
        case (mode)
            0:       return int'($signed(16'($urandom)));
            1:       return $urandom_range(0, 16) - 8;
            default: return corners[$urandom_range(0, 3)];
        endcase
    endfunction

    function automatic face_t random_face();
        face_t f;
        int    mode;
        int    k;
        int    pts [9];
        mode = $urandom_range(0, 9);
        if (mode < 5)
            mode = 0;
        else if (mode < 8)
            mode = 1;
        else
            mode = 2;
        for (int i = 0; i < 9; i++)
            pts[i] = pick_coord(mode);
        f = make_face(kind_t'($urandom_range(0, 3)), pts[0], pts[1], pts[2], pts[3], pts[4],
                      pts[5], pts[6], pts[7], pts[8]);
        // Degenerate faces: coincident vertices, or a third vertex on the line through the first edge.
        case ($urandom_range(0, 11))
            0:
            begin
                for (int i = 0; i < 3; i++)
                    f.c[3 + i] = f.c[i];
            end
            1, 2:
            begin
                k = $urandom_range(0, 6) - 3;
                for (int i = 0; i < 3; i++)
                begin
                    pts[i]     = $urandom_range(0, 200) - 100;
                    pts[3 + i] = $urandom_range(0, 200) - 100;
                    f.c[i]     = pts[i][CB-1:0];
                    f.c[3 + i] = pts[3 + i][CB-1:0];
                    pts[6 + i] = pts[i] + k * (pts[3 + i] - pts[i]);
                    f.c[6 + i] = pts[6 + i][CB-1:0];
                end
            end
            default: ;
        endcase
        return f;
    endfunction

    task automatic send_face(face_t f, bit has_exp, logic [OUT_BITS-1:0] exp_val);
        face_ch.valid  <= 1'b1;
        face_ch.action <= f.kind;
        face_ch.v0_x   <= f.c[0];
        face_ch.v0_y   <= f.c[1];
        face_ch.v0_z   <= f.c[2];
        face_ch.v1_x   <= f.c[3];
        face_ch.v1_y   <= f.c[4];
        face_ch.v1_z   <= f.c[5];
        face_ch.v2_x   <= f.c[6];
        face_ch.v2_y   <= f.c[7];
        face_ch.v2_z   <= f.c[8];
        @(posedge clk);
        while (!face_ch.ready)
            @(posedge clk);
        area_q = {area_q, (has_exp ? exp_val : face_area_halves(f))};
        faces_sent++;
        kind_count[f.kind]++;
    endtask

    // Random gaps between requests, skipped while the tail of the run is quiet.
    task automatic sender_gap();
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            face_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
    endtask

    initial
    begin
        rst_n          <= 1'b0;
        face_ch.valid  <= 1'b0;
        face_ch.action <= '0;
        face_ch.v0_x   <= '0;
        face_ch.v0_y   <= '0;
        face_ch.v0_z   <= '0;
        face_ch.v1_x   <= '0;
        face_ch.v1_y   <= '0;
        face_ch.v1_z   <= '0;
        face_ch.v2_x   <= '0;
        face_ch.v2_y   <= '0;
        face_ch.v2_z   <= '0;
        area_ch.ready  <= 1'b0;
        errors     = 0;
        faces_sent = 0;
        areas_seen = 0;
        kind_count = '{0, 0, 0, 0};
        quiet      = 1'b0;
        hold_req   = 1'b0;
        stim_done  = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        add_row(make_face(KIND_POINT, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, 2);
        add_row(make_face(KIND_POINT, 32767, -32768, 32767, -32768, 32767, -32768,
                          32767, -32768, -1), 1, 2);
        add_row(make_face(KIND_INTERVAL, 5, -5, 7, 5, -5, 7, 1, 2, 3), 1, 0);
        add_row(make_face(KIND_INTERVAL, 0, 0, 0, 1, 0, 0, 0, 0, 0), 1, 2);
        add_row(make_face(KIND_INTERVAL, 0, 0, 0, 3, 4, 0, -32768, 32767, -1), 1, 10);
        add_row(make_face(KIND_INTERVAL, -32768, 0, 0, 32767, 0, 0, 0, 0, 0), 1, 131070);
        add_row(make_face(KIND_INTERVAL, -32768, -32768, -32768, 32767, 32767, 32767,
                          0, 0, 0), 0, 0);
        add_row(make_face(KIND_TRIANGLE, 0, 0, 0, 1, 0, 0, 0, 1, 0), 1, 1);
        add_row(make_face(KIND_PGRAM, 0, 0, 0, 1, 0, 0, 0, 1, 0), 1, 2);
        add_row(make_face(KIND_TRIANGLE, 9, 9, 9, 9, 9, 9, 9, 9, 9), 1, 0);
        add_row(make_face(KIND_TRIANGLE, 0, 0, 0, 1, 1, 1, 2, 2, 2), 1, 0);
        add_row(make_face(KIND_PGRAM, -4, 2, 6, -2, 3, 9, 2, 5, 15), 1, 0);
        add_row(make_face(KIND_TRIANGLE, -32768, -32768, -32768, 32767, -32768, -32768,
                          -32768, 32767, -32768), 1, 35'd4294836225);
        add_row(make_face(KIND_PGRAM, -32768, -32768, -32768, 32767, -32768, -32768,
                          -32768, 32767, -32768), 1, 35'd8589672450);
        add_row(make_face(KIND_TRIANGLE, -32768, 32767, -32768, 32767, -32768, 32767,
                          32767, 32767, -32768), 0, 0);
        add_row(make_face(KIND_PGRAM, 32767, -32768, 0, -32768, 0, 32767, 0, 32767,
                          -32768), 0, 0);
        add_row(make_face(KIND_PGRAM, -32768, -32768, -32768, 0, 0, 0, 32767, 32767,
                          32767), 0, 0);
        add_row(make_face(KIND_TRIANGLE, 1, 2, 3, 4, 5, 6, -7, 8, -9), 0, 0);

        foreach (directed_rows[i])
        begin
            send_face(directed_rows[i].f, directed_rows[i].has_exp, directed_rows[i].exp_val);
            sender_gap();
        end

        // Let the pipeline drain completely before the random part.
        face_ch.valid <= 1'b0;
        while (area_q.size() != 0)
            @(posedge clk);

        for (int n = 0; n < RANDOM_N; n++)
        begin
            if (n == 300)
                hold_req = 1'b1;
            if (n == RANDOM_N - QUIET_TAIL)
                quiet = 1'b1;
            send_face(random_face(), 0, '0);
            sender_gap();
        end
        face_ch.valid <= 1'b0;
        stim_done = 1'b1;

        while (area_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        $display("Run covered %0d faces: %0d point, %0d interval, %0d triangle, %0d pgram.",
                 faces_sent, kind_count[0], kind_count[1], kind_count[2], kind_count[3]);
        $display("%0d areas checked, including degenerate, extreme and saturating corners.",
                 areas_seen);
        if (errors == 0 && area_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Result side: random back-pressure bursts, plus one long hold-off on request.
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                area_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_req = 1'b0;
            end
            else if (!quiet && $urandom_range(0, 3) == 0)
            begin
                area_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
            end
            else
            begin
                area_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && area_ch.valid && area_ch.ready)
        begin
            areas_seen++;
            if (area_q.size() == 0)
            begin
                errors++;
                $display("%0t: area_halves %0d arrived with no request outstanding",
                         $time, area_ch.area_halves);
            end
            else if (area_ch.area_halves !== area_q[0])
            begin
                errors++;
                $display("%0t: area_halves mismatch, expected %0d, got %0d",
                         $time, area_q[0], area_ch.area_halves);
                void'(area_q.pop_front());
            end
            else
                void'(area_q.pop_front());
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (face_ch.valid && face_ch.ready) || (area_ch.valid && area_ch.ready)
            || (stim_done && area_q.size() == 0))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

endmodule
